FILE: src/keys_to_pointer_momentum_assert.svh
// Assertion macros shared by the keyboard-pointer RTL.
// Include guard keeps repeated includes harmless; no other dependencies.
`ifndef KEYS_TO_POINTER_MOMENTUM_ASSERT_SVH
`define KEYS_TO_POINTER_MOMENTUM_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define KPM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("kpm assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define KPM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("kpm assertion failed");

`endif

FILE: src/kpm_pkg.sv
// Package for the keyboard-to-pointer block: widths, key codes, types and
// the per-axis momentum step. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package kpm_pkg;

    localparam int MOMENTUM_BITS = 8;
    localparam int LIMIT_W       = 7;
    localparam int LIMIT_CMP_W   = MOMENTUM_BITS + 8;
    localparam int unsigned MOM_CAP = (1 << (MOMENTUM_BITS - 1)) - 1;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd10;

    localparam logic [7:0] KEY_LEFT  = 8'h25;
    localparam logic [7:0] KEY_UP    = 8'h26;
    localparam logic [7:0] KEY_RIGHT = 8'h27;
    localparam logic [7:0] KEY_DOWN  = 8'h28;
    localparam logic [7:0] KEY_Q     = 8'h51;
    localparam logic [7:0] KEY_W     = 8'h57;
    localparam logic [7:0] KEY_E     = 8'h45;

    // direction_held bit positions
    localparam int DIR_LEFT  = 0;
    localparam int DIR_RIGHT = 1;
    localparam int DIR_UP    = 2;
    localparam int DIR_DOWN  = 3;

    // button bit positions
    localparam int BTN_LEFT   = 0;
    localparam int BTN_MIDDLE = 1;
    localparam int BTN_RIGHT  = 2;

    typedef enum logic [1:0] {
        ACT_KEY_DOWN = 2'd0,
        ACT_KEY_UP   = 2'd1,
        ACT_TICK     = 2'd2
    } t_action;

    typedef logic signed [MOMENTUM_BITS-1:0] t_mom;
    typedef logic signed [7:0]               t_move;
    typedef logic [2:0]                      t_buttons;

    typedef struct packed {
        logic     consumed;
        t_move    move_x;
        t_move    move_y;
        t_buttons button_press;
        t_buttons button_release;
    } t_result;

    // One momentum step: toward neg/pos (neg wins), else decay toward zero.
    function automatic t_mom step_axis(input t_mom m, input logic neg,
                                       input logic pos, input t_mom lim);
        t_mom r;
        r = m;
        if (neg) begin
            if (m > -lim) r = t_mom'(m - t_mom'(1));
        end else if (pos) begin
            if (m < lim) r = t_mom'(m + t_mom'(1));
        end else if (m != t_mom'(0)) begin
            r = m[MOMENTUM_BITS-1] ? t_mom'(m + t_mom'(1)) : t_mom'(m - t_mom'(1));
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: src/kpm_if.sv
// Valid/ready channel interfaces for input beats and result beats.
// Depends on kpm_pkg for payload types.
`timescale 1ns / 1ps
`default_nettype none

interface kpm_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [7:0] key_code;
    logic       modifier_held;

    modport source (output valid, output action, output key_code,
                    output modifier_held, input ready);
    modport sink   (input valid, input action, input key_code,
                    input modifier_held, output ready);
endinterface

interface kpm_out_if;
    logic              valid;
    logic              ready;
    logic              consumed;
    kpm_pkg::t_move    move_x;
    kpm_pkg::t_move    move_y;
    kpm_pkg::t_buttons button_press;
    kpm_pkg::t_buttons button_release;

    modport source (output valid, output consumed, output move_x, output move_y,
                    output button_press, output button_release, input ready);
    modport sink   (input valid, input consumed, input move_x, input move_y,
                    input button_press, input button_release, output ready);
endinterface

`default_nettype wire

FILE: src/kpm_core.sv
// State and single-pass update: key flags, momentum, buttons, limit register.
// Depends on kpm_pkg and keys_to_pointer_momentum_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "keys_to_pointer_momentum_assert.svh"

module kpm_core (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [kpm_pkg::LIMIT_W-1:0]    i_cfg_wdata,
    input  wire logic                           i_item_valid,
    input  wire logic [1:0]                     i_action,
    input  wire logic [7:0]                     i_key_code,
    input  wire logic                           i_modifier_held,
    output kpm_pkg::t_result                    o_result
);

    logic [kpm_pkg::LIMIT_W-1:0] r_limit;
    kpm_pkg::t_mom               r_mom_x, r_mom_y, n_mom_x, n_mom_y;
    logic                        r_mod_latched, n_mod_latched;
    logic [3:0]                  r_dir_held, n_dir_held;
    kpm_pkg::t_buttons           r_btn_held, n_btn_held;
    kpm_pkg::t_buttons           r_btn_down, n_btn_down;

    logic [kpm_pkg::LIMIT_CMP_W-1:0] w_lim_ext, w_cap_ext, w_lim_eff;
    kpm_pkg::t_mom                   w_lim;

    assign w_lim_ext = kpm_pkg::LIMIT_CMP_W'(r_limit);
    assign w_cap_ext = kpm_pkg::LIMIT_CMP_W'(kpm_pkg::MOM_CAP);
    assign w_lim_eff = (w_lim_ext < w_cap_ext) ? w_lim_ext : w_cap_ext;
    assign w_lim     = kpm_pkg::t_mom'(w_lim_eff[kpm_pkg::MOMENTUM_BITS-1:0]);

    always_comb begin
        n_mom_x       = r_mom_x;
        n_mom_y       = r_mom_y;
        n_mod_latched = r_mod_latched;
        n_dir_held    = r_dir_held;
        n_btn_held    = r_btn_held;
        n_btn_down    = r_btn_down;
        o_result      = '0;
        case (i_action)
            kpm_pkg::ACT_KEY_DOWN: begin
                if (r_mod_latched) begin
                    if (i_key_code == kpm_pkg::KEY_LEFT)  n_dir_held[kpm_pkg::DIR_LEFT]  = 1'b1;
                    if (i_key_code == kpm_pkg::KEY_RIGHT) n_dir_held[kpm_pkg::DIR_RIGHT] = 1'b1;
                    if (i_key_code == kpm_pkg::KEY_UP)    n_dir_held[kpm_pkg::DIR_UP]    = 1'b1;
                    if (i_key_code == kpm_pkg::KEY_DOWN)  n_dir_held[kpm_pkg::DIR_DOWN]  = 1'b1;
                    if (i_key_code == kpm_pkg::KEY_Q) n_btn_held[kpm_pkg::BTN_LEFT]   = 1'b1;
                    if (i_key_code == kpm_pkg::KEY_W) n_btn_held[kpm_pkg::BTN_MIDDLE] = 1'b1;
                    if (i_key_code == kpm_pkg::KEY_E) n_btn_held[kpm_pkg::BTN_RIGHT]  = 1'b1;
                    o_result.consumed = (n_dir_held != 4'd0) || (n_btn_held != 3'd0);
                end
            end
            kpm_pkg::ACT_KEY_UP: begin
                if (i_key_code == kpm_pkg::KEY_LEFT)  n_dir_held[kpm_pkg::DIR_LEFT]  = 1'b0;
                if (i_key_code == kpm_pkg::KEY_RIGHT) n_dir_held[kpm_pkg::DIR_RIGHT] = 1'b0;
                if (i_key_code == kpm_pkg::KEY_UP)    n_dir_held[kpm_pkg::DIR_UP]    = 1'b0;
                if (i_key_code == kpm_pkg::KEY_DOWN)  n_dir_held[kpm_pkg::DIR_DOWN]  = 1'b0;
                if (i_key_code == kpm_pkg::KEY_Q) n_btn_held[kpm_pkg::BTN_LEFT]   = 1'b0;
                if (i_key_code == kpm_pkg::KEY_W) n_btn_held[kpm_pkg::BTN_MIDDLE] = 1'b0;
                if (i_key_code == kpm_pkg::KEY_E) n_btn_held[kpm_pkg::BTN_RIGHT]  = 1'b0;
            end
            kpm_pkg::ACT_TICK: begin
                n_mod_latched = i_modifier_held;
                n_mom_x = kpm_pkg::step_axis(r_mom_x, r_dir_held[kpm_pkg::DIR_LEFT],
                                             r_dir_held[kpm_pkg::DIR_RIGHT], w_lim);
                n_mom_y = kpm_pkg::step_axis(r_mom_y, r_dir_held[kpm_pkg::DIR_UP],
                                             r_dir_held[kpm_pkg::DIR_DOWN], w_lim);
                o_result.move_x         = kpm_pkg::t_move'(n_mom_x);
                o_result.move_y         = kpm_pkg::t_move'(n_mom_y);
                o_result.button_press   = r_btn_held & ~r_btn_down;
                o_result.button_release = ~r_btn_held & r_btn_down;
                n_btn_down              = r_btn_held;
            end
            default: begin
                // unused action code: no state change, all-zero result
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit       <= kpm_pkg::LIMIT_RESET;
            r_mom_x       <= '0;
            r_mom_y       <= '0;
            r_mod_latched <= 1'b0;
            r_dir_held    <= '0;
            r_btn_held    <= '0;
            r_btn_down    <= '0;
        end else begin
            if (i_cfg_we) r_limit <= i_cfg_wdata;
            if (i_item_valid) begin
                r_mom_x       <= n_mom_x;
                r_mom_y       <= n_mom_y;
                r_mod_latched <= n_mod_latched;
                r_dir_held    <= n_dir_held;
                r_btn_held    <= n_btn_held;
                r_btn_down    <= n_btn_down;
            end
        end
    end

    `KPM_ASSERT_NOW(a_keyup_not_consumed, i_clk, i_rst_n,
        i_item_valid && (i_action == kpm_pkg::ACT_KEY_UP), !o_result.consumed)
    `KPM_ASSERT_NOW(a_press_release_disjoint, i_clk, i_rst_n,
        1'b1, (o_result.button_press & o_result.button_release) == 3'd0)
    `KPM_ASSERT_NEXT(a_key_keeps_momentum, i_clk, i_rst_n,
        i_rst_n && i_item_valid && (i_action != kpm_pkg::ACT_TICK),
        $stable(r_mom_x) && $stable(r_mom_y) && $stable(r_btn_down))
    `KPM_ASSERT_NEXT(a_tick_tracks_buttons, i_clk, i_rst_n,
        i_rst_n && i_item_valid && (i_action == kpm_pkg::ACT_TICK),
        r_btn_down == $past(r_btn_held))

endmodule

`default_nettype wire

FILE: src/keys_to_pointer_momentum.sv
// Keyboard-to-pointer top level: accepts one beat per cycle while the result register
// is not stalled; each beat goes through the input register, then the result register,
// with kpm_core doing the update in one pass between them. A stalled result register
// holds the input register, which still takes a beat while it drains. Result order
// matches input order, one result beat per input beat.
// Depends on kpm_pkg, kpm_if and kpm_core.
`timescale 1ns / 1ps
`default_nettype none

module keys_to_pointer_momentum (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [kpm_pkg::LIMIT_W-1:0] i_cfg_wdata,
    kpm_in_if.sink                           i_in,
    kpm_out_if.source                        o_out
);

    logic             r_in_valid;
    logic [1:0]       r_in_action;
    logic [7:0]       r_in_key_code;
    logic             r_in_mod;
    logic             r_out_valid;
    kpm_pkg::t_result r_out;
    kpm_pkg::t_result w_result;
    logic             w_advance;

    // input register moves into the result register when that one is free
    assign w_advance  = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || w_advance;

    kpm_core u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_item_valid    (w_advance),
        .i_action        (r_in_action),
        .i_key_code      (r_in_key_code),
        .i_modifier_held (r_in_mod),
        .o_result        (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in.valid && i_in.ready) begin
                r_in_valid <= 1'b1;
            end else if (w_advance) begin
                r_in_valid <= 1'b0;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (i_in.valid && i_in.ready) begin
            r_in_action   <= i_in.action;
            r_in_key_code <= i_in.key_code;
            r_in_mod      <= i_in.modifier_held;
        end
        if (w_advance) r_out <= w_result;
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.consumed       = r_out.consumed;
    assign o_out.move_x         = r_out.move_x;
    assign o_out.move_y         = r_out.move_y;
    assign o_out.button_press   = r_out.button_press;
    assign o_out.button_release = r_out.button_release;

endmodule

`default_nettype wire

FILE: test/keys_to_pointer_momentum_test.sv
// Self-checking bench for keys_to_pointer_momentum: directed table, then random
// key/tick traffic. Uses kpm_pkg and the kpm_in_if / kpm_out_if channels; the
// expected results come from a local model, or from the table for typed rows.
`timescale 1ns / 1ps

module keys_to_pointer_momentum_test;
    import kpm_pkg::*;

    localparam logic [1:0] ACT_UNUSED = 2'd3;  // undefined action: no effect, zero result
    localparam t_result ZERO_RESULT = '0;
    localparam t_result FIRST_GLIDE = '{1'b0, -8'sd1, -8'sd1, 3'b111, 3'b000};
    localparam logic [3:0][7:0] DIR_CODES = {KEY_DOWN, KEY_UP, KEY_RIGHT, KEY_LEFT};
    localparam logic [2:0][7:0] BTN_CODES = {KEY_E, KEY_W, KEY_Q};
    localparam int N_ROWS = 24;

    typedef struct {
        logic [1:0] act;
        logic [7:0] key;
        logic       mod;
        bit         typed;
        t_result    want;
    } t_stim_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [LIMIT_W-1:0] i_cfg_wdata;

    kpm_in_if  in_if ();
    kpm_out_if out_if ();

    keys_to_pointer_momentum uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    // pointer model state
    int           mom_x = 0;
    int           mom_y = 0;
    bit           latched_mod = 1'b0;
    logic [3:0]   held_dirs = '0;
    logic [2:0]   held_buttons = '0;
    logic [2:0]   shown_buttons = '0;
    logic [6:0]   limit_now = LIMIT_RESET;

    t_result      results_due [$];
    t_stim_row    directed_rows [0:N_ROWS-1];
    bit           beat_typed = 1'b0;
    t_result      beat_expect = '0;

    int           mismatch_count = 0;
    int           beats_sent = 0;
    int           ticks_seen = 0;
    int           saturated_ticks = 0;
    int           button_edges = 0;
    int           sink_hold = 0;
    bit           sender_steady = 1'b0;
    bit           sink_steady = 1'b0;
    logic [6:0]   random_limit;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #3_000_000;
        $display("Timeout: results still pending: %0d", results_due.size());
        $display("Mismatches found");
        $finish;
    end

    function automatic int nudge_momentum(input int m, input bit to_neg, input bit to_pos,
                                          input int lim);
        if (to_neg) begin
            if (m > -lim) return m - 1;
        end else if (to_pos) begin
            if (m < lim) return m + 1;
        end else if (m != 0) begin
            return (m < 0) ? m + 1 : m - 1;
        end
        return m;
    endfunction

    function automatic t_result advance_pointer_state(input logic [1:0] act,
                                                      input logic [7:0] key, input logic mod);
        t_result r;
        int      lim;
        r = '0;
        case (act)
            ACT_KEY_DOWN: begin
                if (latched_mod) begin
                    if (key == KEY_LEFT) held_dirs[DIR_LEFT] = 1'b1;
                    else if (key == KEY_RIGHT) held_dirs[DIR_RIGHT] = 1'b1;
                    if (key == KEY_UP) held_dirs[DIR_UP] = 1'b1;
                    else if (key == KEY_DOWN) held_dirs[DIR_DOWN] = 1'b1;
                    if (key == KEY_Q) held_buttons[BTN_LEFT] = 1'b1;
                    else if (key == KEY_W) held_buttons[BTN_MIDDLE] = 1'b1;
                    else if (key == KEY_E) held_buttons[BTN_RIGHT] = 1'b1;
                    r.consumed = (held_dirs != '0) || (held_buttons != '0);
                end
            end
            ACT_KEY_UP: begin
                if (key == KEY_LEFT) held_dirs[DIR_LEFT] = 1'b0;
                if (key == KEY_RIGHT) held_dirs[DIR_RIGHT] = 1'b0;
                if (key == KEY_UP) held_dirs[DIR_UP] = 1'b0;
                if (key == KEY_DOWN) held_dirs[DIR_DOWN] = 1'b0;
                if (key == KEY_Q) held_buttons[BTN_LEFT] = 1'b0;
                if (key == KEY_W) held_buttons[BTN_MIDDLE] = 1'b0;
                if (key == KEY_E) held_buttons[BTN_RIGHT] = 1'b0;
            end
            ACT_TICK: begin
                latched_mod = mod;
                lim = (int'(limit_now) < int'(MOM_CAP)) ? int'(limit_now) : int'(MOM_CAP);
                mom_x = nudge_momentum(mom_x, held_dirs[DIR_LEFT], held_dirs[DIR_RIGHT], lim);
                mom_y = nudge_momentum(mom_y, held_dirs[DIR_UP], held_dirs[DIR_DOWN], lim);
                r.move_x = t_move'(mom_x);
                r.move_y = t_move'(mom_y);
                r.button_press = held_buttons & ~shown_buttons;
                r.button_release = ~held_buttons & shown_buttons;
                shown_buttons = held_buttons;
                ticks_seen++;
                if (lim > 0 && (mom_x == lim || mom_x == -lim || mom_y == lim || mom_y == -lim))
                    saturated_ticks++;
                if (r.button_press != '0 || r.button_release != '0) button_edges++;
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int exp_v, input int got_v);
        $display("ERROR %s: expected %0d, got %0d at %0t", what, exp_v, got_v, $realtime);
        mismatch_count++;
    endtask

    // Outputs are checked before the input beat of the same edge is predicted.
    always @(posedge i_clk) begin : scoreboard
        t_result seen;
        t_result want;
        t_result model;
        if (i_rst_n) begin
            if (out_if.valid && out_if.ready) begin
                seen.consumed = out_if.consumed;
                seen.move_x = out_if.move_x;
                seen.move_y = out_if.move_y;
                seen.button_press = out_if.button_press;
                seen.button_release = out_if.button_release;
                if (results_due.size() == 0) begin
                    report_mismatch("result with nothing pending", 0, 1);
                end else begin
                    want = results_due.pop_front();
                    if (seen.consumed !== want.consumed)
                        report_mismatch("consumed", int'(want.consumed), int'(seen.consumed));
                    if (seen.move_x !== want.move_x)
                        report_mismatch("move_x", int'(want.move_x), int'(seen.move_x));
                    if (seen.move_y !== want.move_y)
                        report_mismatch("move_y", int'(want.move_y), int'(seen.move_y));
                    if (seen.button_press !== want.button_press)
                        report_mismatch("button_press", int'(want.button_press),
                                        int'(seen.button_press));
                    if (seen.button_release !== want.button_release)
                        report_mismatch("button_release", int'(want.button_release),
                                        int'(seen.button_release));
                end
                if ($urandom_range(0, 39) == 0) sink_steady = !sink_steady;
                sink_hold = sink_steady ? 0 : $urandom_range(0, 4);
            end
            if (in_if.valid && in_if.ready) begin
                model = advance_pointer_state(in_if.action, in_if.key_code, in_if.modifier_held);
                results_due.push_back(beat_typed ? beat_expect : model);
            end
        end
    end

    initial begin : result_sink
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (sink_hold > 0) begin
                out_if.ready <= 1'b0;
                sink_hold--;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic send_beat(input logic [1:0] act, input logic [7:0] key, input logic mod,
                             input bit typed, input t_result want);
        int gap;
        gap = sender_steady ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.action <= act;
        in_if.key_code <= key;
        in_if.modifier_held <= mod;
        beat_typed <= typed;
        beat_expect <= want;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        beats_sent++;
        @(negedge i_clk);
    endtask

    task automatic drain();
        in_if.valid <= 1'b0;
        while (results_due.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_limit(input logic [6:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        limit_now = value;
    endtask

    // Latch the modifier, hold some keys for a number of ticks, let go, coast.
    task automatic glide(input int hold_ticks);
        logic [3:0] dirs;
        logic [2:0] btns;
        logic [3:0] dirs_up;
        logic [2:0] btns_up;
        int         first;
        int         k;
        int         idx;
        dirs = 4'($urandom_range(0, 15));
        btns = 3'($urandom_range(0, 7));
        first = $urandom_range(0, 3);
        send_beat(ACT_TICK, 8'($urandom_range(0, 255)), 1'b1, 1'b0, ZERO_RESULT);
        for (k = 0; k < 4; k++) begin
            idx = (first + k) % 4;
            if (dirs[idx])
                send_beat(ACT_KEY_DOWN, DIR_CODES[idx], 1'($urandom_range(0, 1)), 1'b0,
                          ZERO_RESULT);
            if (idx < 3 && btns[idx])
                send_beat(ACT_KEY_DOWN, BTN_CODES[idx], 1'($urandom_range(0, 1)), 1'b0,
                          ZERO_RESULT);
        end
        for (k = 0; k < hold_ticks; k++) begin
            // an occasional tick without the modifier drops the latch
            send_beat(ACT_TICK, 8'($urandom_range(0, 255)), $urandom_range(0, 15) != 0, 1'b0,
                      ZERO_RESULT);
            if ($urandom_range(0, 7) == 0)
                send_beat(ACT_KEY_DOWN, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                          1'b0, ZERO_RESULT);
        end
        dirs_up = ($urandom_range(0, 3) != 0) ? dirs : (dirs & 4'($urandom_range(0, 15)));
        btns_up = ($urandom_range(0, 3) != 0) ? btns : (btns & 3'($urandom_range(0, 7)));
        for (k = 0; k < 4; k++) begin
            if (dirs_up[k])
                send_beat(ACT_KEY_UP, DIR_CODES[k], 1'($urandom_range(0, 1)), 1'b0,
                          ZERO_RESULT);
            if (k < 3 && btns_up[k])
                send_beat(ACT_KEY_UP, BTN_CODES[k], 1'($urandom_range(0, 1)), 1'b0,
                          ZERO_RESULT);
        end
        repeat ($urandom_range(0, 4))
            send_beat(ACT_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0,
                      ZERO_RESULT);
    endtask

    task automatic run_phase(input int n_beats);
        int start;
        start = beats_sent;
        while (beats_sent - start < n_beats) begin
            if ($urandom_range(0, 9) < 7) begin
                glide($urandom_range(1, 16));
            end else begin
                send_beat(2'($urandom_range(0, 3)),
                          ($urandom_range(0, 2) == 0) ? DIR_CODES[$urandom_range(0, 3)]
                                                      : 8'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)), 1'b0, ZERO_RESULT);
            end
            if ($urandom_range(0, 5) == 0) sender_steady = !sender_steady;
        end
    endtask

    initial begin : stimulus
        int row;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        in_if.valid = 1'b0;
        in_if.action = ACT_KEY_DOWN;
        in_if.key_code = '0;
        in_if.modifier_held = 1'b0;

        directed_rows = '{
            '{ACT_KEY_DOWN, KEY_LEFT,  1'b0, 1'b1, ZERO_RESULT},  // modifier not latched yet
            '{ACT_TICK,     8'h00,     1'b1, 1'b1, ZERO_RESULT},
            '{ACT_KEY_DOWN, KEY_LEFT,  1'b0, 1'b0, ZERO_RESULT},
            '{ACT_KEY_DOWN, KEY_RIGHT, 1'b1, 1'b0, ZERO_RESULT},
            '{ACT_KEY_DOWN, KEY_UP,    1'b0, 1'b0, ZERO_RESULT},
            '{ACT_KEY_DOWN, KEY_DOWN,  1'b1, 1'b0, ZERO_RESULT},
            '{ACT_KEY_DOWN, KEY_Q,     1'b0, 1'b0, ZERO_RESULT},
            '{ACT_KEY_DOWN, KEY_W,     1'b1, 1'b0, ZERO_RESULT},
            '{ACT_KEY_DOWN, KEY_E,     1'b0, 1'b0, ZERO_RESULT},
            '{ACT_TICK,     8'hFF,     1'b1, 1'b1, FIRST_GLIDE},  // left and up win
            '{ACT_KEY_DOWN, 8'hFF,     1'b1, 1'b0, ZERO_RESULT},  // other key, still swallowed
            '{ACT_KEY_UP,   KEY_LEFT,  1'b0, 1'b0, ZERO_RESULT},
            '{ACT_KEY_UP,   KEY_UP,    1'b1, 1'b0, ZERO_RESULT},
            '{ACT_TICK,     8'h00,     1'b1, 1'b0, ZERO_RESULT},
            '{ACT_KEY_UP,   KEY_Q,     1'b0, 1'b0, ZERO_RESULT},
            '{ACT_KEY_UP,   KEY_W,     1'b1, 1'b0, ZERO_RESULT},
            '{ACT_KEY_UP,   KEY_E,     1'b0, 1'b0, ZERO_RESULT},
            '{ACT_TICK,     8'hAA,     1'b0, 1'b0, ZERO_RESULT},
            '{ACT_UNUSED,   8'hFF,     1'b1, 1'b1, ZERO_RESULT},
            '{ACT_KEY_DOWN, KEY_RIGHT, 1'b1, 1'b0, ZERO_RESULT},  // latch dropped by last tick
            '{ACT_KEY_UP,   KEY_RIGHT, 1'b0, 1'b0, ZERO_RESULT},
            '{ACT_KEY_UP,   KEY_DOWN,  1'b0, 1'b0, ZERO_RESULT},
            '{ACT_TICK,     8'h55,     1'b0, 1'b0, ZERO_RESULT},
            '{ACT_KEY_DOWN, 8'h00,     1'b0, 1'b0, ZERO_RESULT}
        };

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (row = 0; row < N_ROWS; row++)
            send_beat(directed_rows[row].act, directed_rows[row].key, directed_rows[row].mod,
                      directed_rows[row].typed, directed_rows[row].want);

        drain();
        write_limit(7'd1);
        run_phase(150);
        drain();
        write_limit(7'd127);
        run_phase(150);
        glide($urandom_range(130, 150));  // long enough for a held axis to reach the limit
        drain();
        write_limit(7'd3);  // momentum now far outside the new limit
        run_phase(150);
        drain();
        write_limit(7'd0);
        run_phase(150);
        drain();
        random_limit = 7'($urandom_range(1, 127));
        write_limit(random_limit);
        run_phase(150);
        drain();
        write_limit(LIMIT_RESET);
        run_phase(150);
        drain();

        repeat (6) @(negedge i_clk);
        if (results_due.size() != 0)
            report_mismatch("results never delivered", 0, results_due.size());
        $display("Covered %0d beats, %0d ticks, %0d ticks at a momentum limit, %0d button edges",
                 beats_sent, ticks_seen, saturated_ticks, button_edges);
        $display("Limits used: 10, 1, 127, 3, 0, %0d, 10", random_limit);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
